@@ rtl/plbu_pkg.sv @@
// Package for the price level book update block: item, result and level types,
// action codes, controller/datapath command and status structs, price helpers.
// No dependencies.
package plbu_pkg;

    localparam logic [2:0] ACT_ADD_TOP       = 3'd0;
    localparam logic [2:0] ACT_CANCEL_TOP    = 3'd1;
    localparam logic [2:0] ACT_ADD_DEEP      = 3'd2;
    localparam logic [2:0] ACT_CANCEL_DEEP   = 3'd3;
    localparam logic [2:0] ACT_LOAD_LEVEL    = 3'd4;
    localparam logic [2:0] ACT_APPEND_HIDDEN = 3'd5;
    localparam logic [2:0] ACT_CLEAR_HIDDEN  = 3'd6;

    localparam logic [15:0] CNT_MAX   = 16'hFFFF;
    localparam logic [7:0]  GAP_RESET = 8'd2;

    typedef struct packed {
        logic [2:0]         action;
        logic               side;
        logic [2:0]         level;
        logic signed [31:0] price;
        logic [15:0]        count;
        logic [15:0]        size;
        logic [15:0]        distance;
        logic [15:0]        draw;
    } item_t;

    typedef struct packed {
        logic               applied;
        logic signed [31:0] best_ask_price;
        logic [15:0]        best_ask_count;
        logic signed [31:0] best_bid_price;
        logic [15:0]        best_bid_count;
    } result_t;

    typedef struct packed {
        logic signed [31:0] price;
        logic [15:0]        count;
        logic [15:0]        size;
        logic               syn;
    } level_t;

    typedef enum logic [3:0] {
        LOP_NONE,
        LOP_BUMP,
        LOP_DEC,
        LOP_INSERT,
        LOP_REMOVE,
        LOP_SET_HID,
        LOP_SET_SYN,
        LOP_CLEAR_LAST,
        LOP_LOAD
    } lop_t;

    typedef enum logic [1:0] {
        K_HOLD,
        K_ZERO,
        K_ONE,
        K_INC
    } kop_t;

    typedef enum logic [1:0] {
        H_HOLD,
        H_ZERO,
        H_INC
    } hop_t;

    typedef enum logic [1:0] {
        F_HOLD,
        F_INC,
        F_DEC,
        F_CLR
    } fop_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_TOP_INS,
        ST_DEEP_SCAN,
        ST_TOTAL,
        ST_MUL,
        ST_PICK,
        ST_REMOVE,
        ST_REFILL,
        ST_HREAD,
        ST_HCHK,
        ST_SREAD,
        ST_SWRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic np_load;
        lop_t lop;
        kop_t k_op;
        hop_t h_op;
        fop_t f_op;
        logic tot_clr;
        logic tot_acc;
        logic u_load;
        logic sum_clr;
        logic sum_acc;
        logic ram_rd;
        logic app_wr;
        logic sh_wr;
        logic app_set;
        logic app_clr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       dist_zero;
        logic       cnt0_zero;
        logic       k_cnt_zero;
        logic       k_cnt_one;
        logic       k_real;
        logic       k_match;
        logic       k_deeper;
        logic       k_at_last;
        logic       u_lt_sum;
        logic       load_ok;
        logic       fill_full;
        logic       fill_zero;
        logic       lm2_nonzero;
        logic       h_deeper;
        logic       h_next_end;
    } sts_t;

    // move a price by d ticks, saturating to the signed 32-bit range
    function automatic logic signed [31:0] sat_move(input logic signed [31:0] p,
                                                    input logic [15:0] d,
                                                    input logic neg);
        logic signed [32:0] ext;
        logic signed [32:0] dd;
        logic signed [32:0] sum;
        ext = {p[31], p};
        dd  = {17'd0, d};
        sum = neg ? (ext - dd) : (ext + dd);
        if (sum[32] != sum[31])
        begin
            sat_move = sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
        else
        begin
            sat_move = sum[31:0];
        end
    endfunction

    // a strictly deeper than b: higher on the ask side, lower on the bid side
    function automatic logic is_deeper(input logic side,
                                       input logic signed [31:0] a,
                                       input logic signed [31:0] b);
        is_deeper = side ? (a < b) : (a > b);
    endfunction

endpackage

@@ rtl/plbu_if.sv @@
// Valid/ready channel interfaces for book action words and result words.
// Depends on plbu_pkg for the payload types.
interface plbu_item_if;
    logic             valid;
    logic             ready;
    plbu_pkg::item_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface plbu_result_if;
    logic              valid;
    logic              ready;
    plbu_pkg::result_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/price_level_book_update_core.sv @@
// Two-sided price level book update core, one action word at a time.
// A removal refills the last level from the hidden list, which is scanned and
// compacted through the single read port RAM. Throughput: one word in flight;
// the next word is taken in the cycle that result valid rises, and a stalled
// result holds the sequencer.
// Reset: all levels empty and zero, hidden lists empty, synthetic gap 2.
module price_level_book_update_core #(
    parameter int LEVELS       = 8,
    parameter int HIDDEN_DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata,
    plbu_item_if.sink     item,
    plbu_result_if.source result
);
    // The sequencer holds the action word in the datapath, walks the levels
    // of the addressed side one per cycle where a scan is needed, and finishes
    // into the result register. A new word is taken as soon as the sequencer is
    // back in idle, even while the previous result still waits on the sink.

    plbu_pkg::cmd_t cmd;
    plbu_pkg::sts_t sts;

    plbu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: level registers, hidden RAM, counters and result word.
    plbu_dp #(
        .LEVELS       (LEVELS),
        .HIDDEN_DEPTH (HIDDEN_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_word   (item.payload),
        .out_word  (result.payload),
        .cmd       (cmd),
        .sts       (sts)
    );
endmodule

@@ rtl/plbu_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module plbu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ rtl/plbu_ctrl.sv @@
// Sequencer for the book update: one action word at a time through dispatch,
// level scans, refill from the hidden list and the result register.
// Depends on plbu_pkg.
module plbu_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            out_ready,
    output logic            out_valid,
    input  plbu_pkg::sts_t  sts,
    output plbu_pkg::cmd_t  cmd
);
    plbu_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plbu_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            plbu_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = plbu_pkg::ST_DISPATCH;
                end
            end
            plbu_pkg::ST_DISPATCH:
            begin
                state_next = plbu_pkg::ST_OUT;
                case (sts.action)
                    plbu_pkg::ACT_ADD_TOP:
                    begin
                        if (!sts.dist_zero)
                        begin
                            state_next = plbu_pkg::ST_TOP_INS;
                        end
                    end
                    plbu_pkg::ACT_CANCEL_TOP:
                    begin
                        if (!sts.cnt0_zero && sts.k_cnt_one)
                        begin
                            state_next = plbu_pkg::ST_REMOVE;
                        end
                    end
                    plbu_pkg::ACT_ADD_DEEP:
                    begin
                        if (!sts.dist_zero)
                        begin
                            state_next = plbu_pkg::ST_DEEP_SCAN;
                        end
                    end
                    plbu_pkg::ACT_CANCEL_DEEP:
                    begin
                        state_next = plbu_pkg::ST_TOTAL;
                    end
                    default:
                    begin
                        state_next = plbu_pkg::ST_OUT;
                    end
                endcase
            end
            plbu_pkg::ST_TOP_INS:
            begin
                state_next = plbu_pkg::ST_OUT;
            end
            plbu_pkg::ST_DEEP_SCAN:
            begin
                if (sts.k_cnt_zero || sts.k_match || sts.k_deeper || sts.k_at_last)
                begin
                    state_next = plbu_pkg::ST_OUT;
                end
            end
            plbu_pkg::ST_TOTAL:
            begin
                if (sts.k_at_last)
                begin
                    state_next = plbu_pkg::ST_MUL;
                end
            end
            plbu_pkg::ST_MUL:
            begin
                state_next = plbu_pkg::ST_PICK;
            end
            plbu_pkg::ST_PICK:
            begin
                if (sts.k_real && sts.u_lt_sum)
                begin
                    state_next = sts.k_cnt_one ? plbu_pkg::ST_REMOVE : plbu_pkg::ST_OUT;
                end
                else if (sts.k_at_last)
                begin
                    state_next = plbu_pkg::ST_OUT;
                end
            end
            plbu_pkg::ST_REMOVE:
            begin
                state_next = plbu_pkg::ST_REFILL;
            end
            plbu_pkg::ST_REFILL:
            begin
                if (!sts.lm2_nonzero || sts.fill_zero)
                begin
                    state_next = plbu_pkg::ST_OUT;
                end
                else
                begin
                    state_next = plbu_pkg::ST_HREAD;
                end
            end
            plbu_pkg::ST_HREAD:
            begin
                state_next = plbu_pkg::ST_HCHK;
            end
            plbu_pkg::ST_HCHK:
            begin
                if (sts.h_next_end)
                begin
                    state_next = plbu_pkg::ST_OUT;
                end
                else
                begin
                    state_next = sts.h_deeper ? plbu_pkg::ST_SREAD : plbu_pkg::ST_HREAD;
                end
            end
            plbu_pkg::ST_SREAD:
            begin
                state_next = plbu_pkg::ST_SWRITE;
            end
            plbu_pkg::ST_SWRITE:
            begin
                state_next = sts.h_next_end ? plbu_pkg::ST_OUT : plbu_pkg::ST_SREAD;
            end
            plbu_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next     = plbu_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = plbu_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            plbu_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.app_clr = 1'b1;
                    cmd.k_op    = plbu_pkg::K_ZERO;
                end
            end
            plbu_pkg::ST_DISPATCH:
            begin
                cmd.np_load = 1'b1;
                case (sts.action)
                    plbu_pkg::ACT_ADD_TOP:
                    begin
                        cmd.app_set = 1'b1;
                        if (sts.dist_zero)
                        begin
                            cmd.lop = plbu_pkg::LOP_BUMP;
                        end
                    end
                    plbu_pkg::ACT_CANCEL_TOP:
                    begin
                        if (!sts.cnt0_zero)
                        begin
                            cmd.app_set = 1'b1;
                            if (!sts.k_cnt_one)
                            begin
                                cmd.lop = plbu_pkg::LOP_DEC;
                            end
                        end
                    end
                    plbu_pkg::ACT_ADD_DEEP:
                    begin
                        cmd.k_op = plbu_pkg::K_ONE;
                    end
                    plbu_pkg::ACT_CANCEL_DEEP:
                    begin
                        cmd.k_op    = plbu_pkg::K_ONE;
                        cmd.tot_clr = 1'b1;
                    end
                    plbu_pkg::ACT_LOAD_LEVEL:
                    begin
                        if (sts.load_ok)
                        begin
                            cmd.lop     = plbu_pkg::LOP_LOAD;
                            cmd.app_set = 1'b1;
                        end
                    end
                    plbu_pkg::ACT_APPEND_HIDDEN:
                    begin
                        if (!sts.fill_full)
                        begin
                            cmd.app_wr  = 1'b1;
                            cmd.f_op    = plbu_pkg::F_INC;
                            cmd.app_set = 1'b1;
                        end
                    end
                    plbu_pkg::ACT_CLEAR_HIDDEN:
                    begin
                        cmd.app_set = !sts.fill_zero;
                        cmd.f_op    = plbu_pkg::F_CLR;
                    end
                    default:
                    begin
                        cmd.np_load = 1'b1;
                    end
                endcase
            end
            plbu_pkg::ST_TOP_INS:
            begin
                cmd.lop = plbu_pkg::LOP_INSERT;
            end
            plbu_pkg::ST_DEEP_SCAN:
            begin
                if (sts.k_cnt_zero)
                begin
                    cmd.lop     = plbu_pkg::LOP_INSERT;
                    cmd.app_set = 1'b1;
                end
                else if (sts.k_match)
                begin
                    cmd.lop     = plbu_pkg::LOP_BUMP;
                    cmd.app_set = 1'b1;
                end
                else if (sts.k_deeper)
                begin
                    cmd.lop     = plbu_pkg::LOP_INSERT;
                    cmd.app_set = 1'b1;
                end
                else if (!sts.k_at_last)
                begin
                    cmd.k_op = plbu_pkg::K_INC;
                end
            end
            plbu_pkg::ST_TOTAL:
            begin
                cmd.tot_acc = 1'b1;
                if (!sts.k_at_last)
                begin
                    cmd.k_op = plbu_pkg::K_INC;
                end
            end
            plbu_pkg::ST_MUL:
            begin
                cmd.u_load  = 1'b1;
                cmd.sum_clr = 1'b1;
                cmd.k_op    = plbu_pkg::K_ONE;
            end
            plbu_pkg::ST_PICK:
            begin
                if (sts.k_real && sts.u_lt_sum)
                begin
                    cmd.app_set = 1'b1;
                    if (!sts.k_cnt_one)
                    begin
                        cmd.lop = plbu_pkg::LOP_DEC;
                    end
                end
                else
                begin
                    cmd.sum_acc = 1'b1;
                    if (!sts.k_at_last)
                    begin
                        cmd.k_op = plbu_pkg::K_INC;
                    end
                end
            end
            plbu_pkg::ST_REMOVE:
            begin
                cmd.lop = plbu_pkg::LOP_REMOVE;
            end
            plbu_pkg::ST_REFILL:
            begin
                if (!sts.lm2_nonzero)
                begin
                    cmd.lop = plbu_pkg::LOP_CLEAR_LAST;
                end
                else if (sts.fill_zero)
                begin
                    cmd.lop = plbu_pkg::LOP_SET_SYN;
                end
                else
                begin
                    cmd.h_op = plbu_pkg::H_ZERO;
                end
            end
            plbu_pkg::ST_HREAD:
            begin
                cmd.ram_rd = 1'b1;
            end
            plbu_pkg::ST_HCHK:
            begin
                cmd.h_op = plbu_pkg::H_INC;
                if (sts.h_deeper)
                begin
                    cmd.lop = plbu_pkg::LOP_SET_HID;
                    if (sts.h_next_end)
                    begin
                        cmd.f_op = plbu_pkg::F_DEC;
                    end
                end
                else if (sts.h_next_end)
                begin
                    cmd.lop = plbu_pkg::LOP_SET_SYN;
                end
            end
            plbu_pkg::ST_SREAD:
            begin
                cmd.ram_rd = 1'b1;
            end
            plbu_pkg::ST_SWRITE:
            begin
                cmd.sh_wr = 1'b1;
                cmd.h_op  = plbu_pkg::H_INC;
                if (sts.h_next_end)
                begin
                    cmd.f_op = plbu_pkg::F_DEC;
                end
            end
            plbu_pkg::ST_OUT:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end
endmodule

@@ rtl/plbu_dp.sv @@
// Datapath of the book update: level registers for both sides, hidden price
// RAM with fill counts, scan counters, weighted pick arithmetic, result word.
// Depends on plbu_pkg and plbu_ram.
module plbu_dp #(
    parameter int LEVELS       = 8,
    parameter int HIDDEN_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    input  plbu_pkg::item_t   in_word,
    output plbu_pkg::result_t out_word,
    input  plbu_pkg::cmd_t    cmd,
    output plbu_pkg::sts_t    sts
);
    localparam int LW = $clog2(LEVELS);
    localparam int FW = $clog2(HIDDEN_DEPTH + 1);
    localparam int AW = $clog2(2 * HIDDEN_DEPTH);
    localparam int TW = 16 + $clog2(LEVELS);
    localparam int PW = 16 + TW;

    plbu_pkg::item_t    item_reg;
    plbu_pkg::result_t  res_reg;
    plbu_pkg::level_t   lv_reg  [2][LEVELS];
    plbu_pkg::level_t   lv_next [2][LEVELS];
    plbu_pkg::level_t   lv_k;
    logic [7:0]         gap_reg;
    logic [FW-1:0]      fill_reg [2];
    logic [LW-1:0]      k_reg;
    logic [FW-1:0]      h_reg;
    logic signed [31:0] np_reg;
    logic [TW-1:0]      total_reg;
    logic [TW-1:0]      sum_reg;
    logic [TW-1:0]      u_reg;
    logic               applied_reg;
    logic [PW-1:0]      prod;
    logic               s;
    logic [AW-1:0]      base;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [31:0]        ram_rdata;
    logic signed [31:0] syn_price;

    assign s    = item_reg.side;
    assign lv_k = lv_reg[s][k_reg];
    assign base = s ? AW'(HIDDEN_DEPTH) : '0;
    assign prod = PW'(item_reg.draw) * PW'(total_reg);
    assign syn_price = plbu_pkg::sat_move(lv_reg[s][LEVELS-2].price, {8'd0, gap_reg}, s);

    // hidden price store, both sides, side 1 above side 0
    assign ram_we    = cmd.app_wr || cmd.sh_wr;
    assign ram_waddr = cmd.app_wr ? (base + AW'(fill_reg[s]))
                                  : (base + AW'(h_reg - FW'(1)));
    assign ram_wdata = cmd.app_wr ? item_reg.price : ram_rdata;
    assign ram_raddr = base + AW'(h_reg);

    plbu_ram #(
        .WIDTH (32),
        .DEPTH (2 * HIDDEN_DEPTH)
    ) u_hidden (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.ram_rd),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // status towards the sequencer
    always_comb
    begin
        sts.action      = item_reg.action;
        sts.dist_zero   = item_reg.distance == 16'd0;
        sts.cnt0_zero   = lv_reg[s][0].count == 16'd0;
        sts.k_cnt_zero  = lv_k.count == 16'd0;
        sts.k_cnt_one   = lv_k.count == 16'd1;
        sts.k_real      = (lv_k.count != 16'd0) && !lv_k.syn;
        sts.k_match     = !lv_k.syn && (lv_k.price == np_reg);
        sts.k_deeper    = plbu_pkg::is_deeper(s, lv_k.price, np_reg);
        sts.k_at_last   = k_reg == LW'(LEVELS - 1);
        sts.u_lt_sum    = u_reg < (sum_reg + TW'(lv_k.count));
        sts.load_ok     = {29'd0, item_reg.level} < 32'(LEVELS);
        sts.fill_full   = fill_reg[s] == FW'(HIDDEN_DEPTH);
        sts.fill_zero   = fill_reg[s] == '0;
        sts.lm2_nonzero = lv_reg[s][LEVELS-2].count != 16'd0;
        sts.h_deeper    = plbu_pkg::is_deeper(s, $signed(ram_rdata),
                                              lv_reg[s][LEVELS-2].price);
        sts.h_next_end  = ({1'b0, h_reg} + (FW+1)'(1)) >= {1'b0, fill_reg[s]};
    end

    // level operations on the selected side
    always_comb
    begin
        lv_next = lv_reg;
        case (cmd.lop)
            plbu_pkg::LOP_BUMP:
            begin
                for (int j = 0; j < LEVELS; j++)
                begin
                    if (k_reg == LW'(j))
                    begin
                        if (lv_reg[s][j].count != plbu_pkg::CNT_MAX)
                        begin
                            lv_next[s][j].count = lv_reg[s][j].count + 16'd1;
                        end
                        if (lv_reg[s][j].size != plbu_pkg::CNT_MAX)
                        begin
                            lv_next[s][j].size = lv_reg[s][j].size + 16'd1;
                        end
                    end
                end
            end
            plbu_pkg::LOP_DEC:
            begin
                for (int j = 0; j < LEVELS; j++)
                begin
                    if (k_reg == LW'(j))
                    begin
                        lv_next[s][j].count = lv_reg[s][j].count - 16'd1;
                        if (lv_reg[s][j].size != 16'd0)
                        begin
                            lv_next[s][j].size = lv_reg[s][j].size - 16'd1;
                        end
                    end
                end
            end
            plbu_pkg::LOP_INSERT:
            begin
                for (int j = 1; j < LEVELS; j++)
                begin
                    if (LW'(j) > k_reg)
                    begin
                        lv_next[s][j] = lv_reg[s][j-1];
                    end
                end
                for (int j = 0; j < LEVELS; j++)
                begin
                    if (LW'(j) == k_reg)
                    begin
                        lv_next[s][j] = '{price: np_reg, count: 16'd1, size: 16'd1,
                                          syn: 1'b0};
                    end
                end
            end
            plbu_pkg::LOP_REMOVE:
            begin
                for (int j = 0; j < LEVELS - 1; j++)
                begin
                    if (LW'(j) >= k_reg)
                    begin
                        lv_next[s][j] = lv_reg[s][j+1];
                    end
                end
            end
            plbu_pkg::LOP_SET_HID:
            begin
                lv_next[s][LEVELS-1] = '{price: $signed(ram_rdata), count: 16'd1,
                                         size: 16'd1, syn: 1'b0};
            end
            plbu_pkg::LOP_SET_SYN:
            begin
                lv_next[s][LEVELS-1] = '{price: syn_price, count: 16'd1, size: 16'd1,
                                         syn: 1'b1};
            end
            plbu_pkg::LOP_CLEAR_LAST:
            begin
                lv_next[s][LEVELS-1] = '0;
            end
            plbu_pkg::LOP_LOAD:
            begin
                for (int j = 0; j < LEVELS; j++)
                begin
                    if ({29'd0, item_reg.level} == 32'(j))
                    begin
                        lv_next[s][j] = '{price: item_reg.price, count: item_reg.count,
                                          size: item_reg.size, syn: 1'b0};
                    end
                end
            end
            default:
            begin
                lv_next = lv_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int sd = 0; sd < 2; sd++)
            begin
                for (int j = 0; j < LEVELS; j++)
                begin
                    lv_reg[sd][j] <= '0;
                end
                fill_reg[sd] <= '0;
            end
            gap_reg     <= plbu_pkg::GAP_RESET;
            k_reg       <= '0;
            h_reg       <= '0;
            applied_reg <= 1'b0;
        end
        else
        begin
            lv_reg <= lv_next;
            if (cfg_we)
            begin
                gap_reg <= cfg_wdata;
            end
            case (cmd.k_op)
                plbu_pkg::K_ZERO: k_reg <= '0;
                plbu_pkg::K_ONE:  k_reg <= LW'(1);
                plbu_pkg::K_INC:  k_reg <= k_reg + LW'(1);
                default:          k_reg <= k_reg;
            endcase
            case (cmd.h_op)
                plbu_pkg::H_ZERO: h_reg <= '0;
                plbu_pkg::H_INC:  h_reg <= h_reg + FW'(1);
                default:          h_reg <= h_reg;
            endcase
            case (cmd.f_op)
                plbu_pkg::F_INC: fill_reg[s] <= fill_reg[s] + FW'(1);
                plbu_pkg::F_DEC: fill_reg[s] <= fill_reg[s] - FW'(1);
                plbu_pkg::F_CLR: fill_reg[s] <= '0;
                default:         fill_reg[s] <= fill_reg[s];
            endcase
            if (cmd.app_clr)
            begin
                applied_reg <= 1'b0;
            end
            else if (cmd.app_set)
            begin
                applied_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_word;
        end
        if (cmd.np_load)
        begin
            // inside the best for add at top, deeper for add deeper
            np_reg <= plbu_pkg::sat_move(lv_reg[s][0].price, item_reg.distance,
                          (item_reg.action == plbu_pkg::ACT_ADD_TOP) ^ s);
        end
        if (cmd.tot_clr)
        begin
            total_reg <= '0;
        end
        else if (cmd.tot_acc && sts.k_real)
        begin
            total_reg <= total_reg + TW'(lv_k.count);
        end
        if (cmd.sum_clr)
        begin
            sum_reg <= '0;
        end
        else if (cmd.sum_acc && sts.k_real)
        begin
            sum_reg <= sum_reg + TW'(lv_k.count);
        end
        if (cmd.u_load)
        begin
            u_reg <= prod[PW-1:16];
        end
        if (cmd.out_load)
        begin
            res_reg.applied        <= applied_reg;
            res_reg.best_ask_price <= lv_reg[0][0].price;
            res_reg.best_ask_count <= lv_reg[0][0].count;
            res_reg.best_bid_price <= lv_reg[1][0].price;
            res_reg.best_bid_count <= lv_reg[1][0].count;
        end
    end

    assign out_word = res_reg;
endmodule

@@ dv/tb_price_level_book_update_core.sv @@
// Self-checking testbench for price_level_book_update_core: directed and random book
// actions, predicted in-bench and compared word by word with the result channel.
// Depends on plbu_pkg, plbu_if and the core RTL.
`timescale 1ns / 1ps

module tb_price_level_book_update_core;

    localparam int NLEV     = 8;
    localparam int HID_MAX  = 64;
    localparam int RANDOM_WORDS = 1400;
    // longest busy spell of the core: removal plus full hidden scan and compaction
    localparam int DRAIN_CYCLES = 4 * HID_MAX + 4 * NLEV + 40;
    // action code with no meaning, ignored by the core
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    plbu_item_if   item_ch ();
    plbu_result_if result_ch ();

    price_level_book_update_core #(
        .LEVELS       (NLEV),
        .HIDDEN_DEPTH (HID_MAX)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    // Shadow copy of the book, the hidden lists and the gap register.
    logic signed [31:0] lvl_price [2][NLEV];
    int unsigned        lvl_count [2][NLEV];
    int unsigned        lvl_size  [2][NLEV];
    bit                 lvl_syn   [2][NLEV];
    logic signed [31:0] hidden_list [2][$];
    int unsigned        gap_ticks;

    plbu_pkg::result_t expected_tops [$];
    int      error_count;
    int      words_sent;
    bit      calm;  // while set, neither side idles nor stalls

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Book predictor
    // ------------------------------------------------------------------

    // clamp a wide price into the signed 32-bit range
    function automatic logic signed [31:0] clamp_price(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // price d ticks further from the touch (ask up, bid down)
    function automatic logic signed [31:0] further_out(input bit s,
                                                       input logic signed [31:0] p,
                                                       input longint d);
        return clamp_price(s ? longint'(p) - d : longint'(p) + d);
    endfunction

    function automatic bit lies_beyond(input bit s, input logic signed [31:0] a,
                                       input logic signed [31:0] b);
        return s ? (a < b) : (a > b);
    endfunction

    task automatic put_level(input bit s, input int k, input logic signed [31:0] p,
                             input int unsigned n, input int unsigned sz, input bit syn);
        lvl_price[s][k] = p;
        lvl_count[s][k] = n;
        lvl_size[s][k]  = sz;
        lvl_syn[s][k]   = syn;
    endtask

    task automatic push_down_from(input bit s, input int k);
        for (int j = NLEV - 1; j > k; j--)
        begin
            put_level(s, j, lvl_price[s][j-1], lvl_count[s][j-1], lvl_size[s][j-1],
                      lvl_syn[s][j-1]);
        end
    endtask

    task automatic add_order(input bit s, input int k);
        if (lvl_count[s][k] < 65535) lvl_count[s][k]++;
        if (lvl_size[s][k] < 65535)  lvl_size[s][k]++;
    endtask

    // drop level k, pull the deeper levels up and refill the tail
    task automatic pull_up_and_refill(input bit s, input int k);
        logic signed [31:0] bottom;
        bit                 found;
        for (int j = k; j < NLEV - 1; j++)
        begin
            put_level(s, j, lvl_price[s][j+1], lvl_count[s][j+1], lvl_size[s][j+1],
                      lvl_syn[s][j+1]);
        end
        if (lvl_count[s][NLEV-2] > 0)
        begin
            bottom = lvl_price[s][NLEV-2];
            found  = 1'b0;
            for (int i = 0; i < hidden_list[s].size(); i++)
            begin
                if (lies_beyond(s, hidden_list[s][i], bottom))
                begin
                    put_level(s, NLEV - 1, hidden_list[s][i], 1, 1, 1'b0);
                    hidden_list[s].delete(i);
                    found = 1'b1;
                    break;
                end
            end
            if (!found)
            begin
                put_level(s, NLEV - 1, further_out(s, bottom, gap_ticks), 1, 1, 1'b1);
            end
        end
        else
        begin
            put_level(s, NLEV - 1, 0, 0, 0, 1'b0);
        end
    endtask

    task automatic take_order(input bit s, input int k);
        lvl_count[s][k]--;
        if (lvl_size[s][k] > 0) lvl_size[s][k]--;
        if (lvl_count[s][k] == 0) pull_up_and_refill(s, k);
    endtask

    // apply one action word to the shadow book and return the top-of-book word
    task automatic apply_book_action(input plbu_pkg::item_t w,
                                     output plbu_pkg::result_t r);
        bit                 s;
        bit                 done;
        int                 k;
        int                 pick;
        longint             total;
        longint             run;
        longint             u;
        logic signed [31:0] np;
        s    = w.side;
        done = 1'b0;
        case (w.action)
            plbu_pkg::ACT_ADD_TOP:
            begin
                if (w.distance == 0)
                begin
                    add_order(s, 0);
                end
                else
                begin
                    np = clamp_price(s ? longint'(lvl_price[s][0]) + w.distance
                                       : longint'(lvl_price[s][0]) - w.distance);
                    push_down_from(s, 0);
                    put_level(s, 0, np, 1, 1, 1'b0);
                end
                done = 1'b1;
            end
            plbu_pkg::ACT_CANCEL_TOP:
            begin
                if (lvl_count[s][0] != 0)
                begin
                    take_order(s, 0);
                    done = 1'b1;
                end
            end
            plbu_pkg::ACT_ADD_DEEP:
            begin
                if (w.distance != 0)
                begin
                    np = further_out(s, lvl_price[s][0], w.distance);
                    for (k = 1; k < NLEV; k++)
                    begin
                        if (lvl_count[s][k] == 0) break;
                        if (!lvl_syn[s][k] && lvl_price[s][k] == np)
                        begin
                            add_order(s, k);
                            done = 1'b1;
                            break;
                        end
                        if (lies_beyond(s, lvl_price[s][k], np)) break;
                    end
                    if (!done && k < NLEV)
                    begin
                        push_down_from(s, k);
                        put_level(s, k, np, 1, 1, 1'b0);
                        done = 1'b1;
                    end
                end
            end
            plbu_pkg::ACT_CANCEL_DEEP:
            begin
                total = 0;
                for (k = 1; k < NLEV; k++)
                begin
                    if (lvl_count[s][k] > 0 && !lvl_syn[s][k]) total += lvl_count[s][k];
                end
                if (total != 0)
                begin
                    u    = (longint'(w.draw) * total) >> 16;
                    run  = 0;
                    pick = 1;
                    for (k = 1; k < NLEV; k++)
                    begin
                        if (lvl_count[s][k] == 0 || lvl_syn[s][k]) continue;
                        run += lvl_count[s][k];
                        if (u < run)
                        begin
                            pick = k;
                            break;
                        end
                    end
                    take_order(s, pick);
                    done = 1'b1;
                end
            end
            plbu_pkg::ACT_LOAD_LEVEL:
            begin
                // level field can address no level beyond the book, so every load lands
                put_level(s, w.level, w.price, w.count, w.size, 1'b0);
                done = 1'b1;
            end
            plbu_pkg::ACT_APPEND_HIDDEN:
            begin
                if (hidden_list[s].size() < HID_MAX)
                begin
                    hidden_list[s].push_back(w.price);
                    done = 1'b1;
                end
            end
            plbu_pkg::ACT_CLEAR_HIDDEN:
            begin
                done = hidden_list[s].size() != 0;
                hidden_list[s].delete();
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
        r.applied        = done;
        r.best_ask_price = lvl_price[0][0];
        r.best_ask_count = lvl_count[0][0][15:0];
        r.best_bid_price = lvl_price[1][0];
        r.best_bid_count = lvl_count[1][0][15:0];
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_cycles();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic plbu_pkg::item_t make_word(input logic [2:0] act, input bit s,
                                        input logic [2:0] lv, input logic [31:0] p,
                                        input logic [15:0] n, input logic [15:0] sz,
                                        input logic [15:0] d, input logic [15:0] dr);
        plbu_pkg::item_t w;
        w.action   = act;
        w.side     = s;
        w.level    = lv;
        w.price    = p;
        w.count    = n;
        w.size     = sz;
        w.distance = d;
        w.draw     = dr;
        return w;
    endfunction

    // present one word, hold it until accepted, then predict its result
    task automatic send_word(input plbu_pkg::item_t w);
        int                gap;
        plbu_pkg::result_t r;
        gap = idle_cycles();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= w;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        apply_book_action(w, r);
        expected_tops.push_back(r);
        words_sent++;
    endtask

    task automatic send_action(input logic [2:0] act, input bit s,
                               input logic [15:0] d, input logic [15:0] dr);
        send_word(make_word(act, s, 3'd0, 32'd0, 16'd0, 16'd0, d, dr));
    endtask

    task automatic load(input bit s, input int k, input logic [31:0] p,
                        input logic [15:0] n, input logic [15:0] sz);
        send_word(make_word(plbu_pkg::ACT_LOAD_LEVEL, s, k[2:0], p, n, sz, 16'd0, 16'd0));
    endtask

    task automatic append_hidden(input bit s, input logic [31:0] p);
        send_word(make_word(plbu_pkg::ACT_APPEND_HIDDEN, s, 3'd0, p, 16'd0, 16'd0,
                            16'd0, 16'd0));
    endtask

    // wait for every outstanding word and for the core to go quiet
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_tops.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_gap(input logic [7:0] g);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= g;
        @(posedge clk);
        cfg_we    <= 1'b0;
        gap_ticks = 32'(g);
    endtask

    // fill a side with a ladder of levels stepping away from the touch
    task automatic load_ladder(input bit s, input logic signed [31:0] base,
                               input int step, input int max_cnt);
        for (int i = 0; i < NLEV; i++)
        begin
            load(s, i, further_out(s, base, longint'(i) * step),
                 16'($urandom_range(1, max_cnt)), 16'($urandom_range(0, max_cnt)));
        end
    endtask

    function automatic plbu_pkg::item_t random_noise_word();
        plbu_pkg::item_t w;
        w = make_word(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      3'($urandom_range(0, 7)), $urandom, 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom));
        if ($urandom_range(0, 3) != 0) w.distance = 16'($urandom_range(0, 8));
        return w;
    endfunction

    // book action within a well-formed episode, weighted towards the busy paths
    function automatic plbu_pkg::item_t random_book_word(input bit s);
        int          r;
        logic [15:0] d;
        r = $urandom_range(0, 99);
        d = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
        if (r < 18) return make_word(plbu_pkg::ACT_ADD_TOP, s, 3'd0, 32'd0, 16'd0, 16'd0,
                                     ($urandom_range(0, 1) != 0) ? 16'd0 : d, 16'd0);
        if (r < 42) return make_word(plbu_pkg::ACT_CANCEL_TOP, s, 3'd0, 32'd0, 16'd0,
                                     16'd0, 16'd0, 16'd0);
        if (r < 62) return make_word(plbu_pkg::ACT_ADD_DEEP, s, 3'd0, 32'd0, 16'd0, 16'd0,
                                     ($urandom_range(0, 15) == 0) ? 16'd0 : d, 16'd0);
        if (r < 86) return make_word(plbu_pkg::ACT_CANCEL_DEEP, s, 3'd0, 32'd0, 16'd0,
                                     16'd0, 16'd0, 16'($urandom));
        if (r < 91) return make_word(plbu_pkg::ACT_LOAD_LEVEL, s, 3'($urandom_range(0, 7)),
                                     $urandom, 16'($urandom_range(0, 6)),
                                     16'($urandom_range(0, 6)), 16'd0, 16'd0);
        if (r < 96) return make_word(plbu_pkg::ACT_APPEND_HIDDEN, s, 3'd0, 32'd0, 16'd0,
                                     16'd0, 16'd0, 16'd0);
        if (r < 99) return make_word(plbu_pkg::ACT_CLEAR_HIDDEN, s, 3'd0, 32'd0, 16'd0,
                                     16'd0, 16'd0, 16'd0);
        return make_word(ACT_UNUSED, s, 3'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    endfunction

    // ------------------------------------------------------------------
    // Result checking and back-pressure
    // ------------------------------------------------------------------

    int stall_left;

    always @(posedge clk)
    begin
        plbu_pkg::result_t want;
        plbu_pkg::result_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.payload;
            if (expected_tops.size() == 0)
            begin
                $error("result word with nothing expected");
                error_count++;
            end
            else
            begin
                want = expected_tops.pop_front();
                if (got.applied !== want.applied)
                begin
                    $error("applied expected %0d got %0d", want.applied, got.applied);
                    error_count++;
                end
                if (got.best_ask_price !== want.best_ask_price)
                begin
                    $error("best_ask_price expected %0d got %0d", want.best_ask_price,
                           got.best_ask_price);
                    error_count++;
                end
                if (got.best_ask_count !== want.best_ask_count)
                begin
                    $error("best_ask_count expected %0d got %0d", want.best_ask_count,
                           got.best_ask_count);
                    error_count++;
                end
                if (got.best_bid_price !== want.best_bid_price)
                begin
                    $error("best_bid_price expected %0d got %0d", want.best_bid_price,
                           got.best_bid_price);
                    error_count++;
                end
                if (got.best_bid_count !== want.best_bid_count)
                begin
                    $error("best_bid_count expected %0d got %0d", want.best_bid_count,
                           got.best_bid_count);
                    error_count++;
                end
            end
        end
        // stall the result side: mostly short, now and then long
        if (calm)
        begin
            result_ch.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: stall_left = $urandom_range(0, 3);
                4:          stall_left = $urandom_range(10, 40);
                default:    stall_left = 0;
            endcase
            result_ch.ready <= (stall_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // edges of the fields, every action and the corner cases of each
    task automatic test_directed();
        // empty book: join top opens count 1 at price 0, cancels drain it
        send_action(plbu_pkg::ACT_ADD_TOP, 1'b0, 16'd0, 16'd0);
        send_action(plbu_pkg::ACT_CANCEL_TOP, 1'b0, 16'd0, 16'd0);
        send_action(plbu_pkg::ACT_CANCEL_TOP, 1'b0, 16'd0, 16'd0);
        send_action(plbu_pkg::ACT_CANCEL_DEEP, 1'b1, 16'd0, 16'hFFFF);
        // add deeper with distance 0 is dropped
        send_action(plbu_pkg::ACT_ADD_DEEP, 1'b0, 16'd0, 16'd0);
        // new best on an empty book, then deeper insert
        send_action(plbu_pkg::ACT_ADD_TOP, 1'b1, 16'hFFFF, 16'd0);
        send_action(plbu_pkg::ACT_ADD_DEEP, 1'b1, 16'hFFFF, 16'd0);
        // price saturation at both ends of the range
        load(1'b1, 0, 32'h7FFF_FFF0, 16'd3, 16'd3);
        send_action(plbu_pkg::ACT_ADD_TOP, 1'b1, 16'hFFFF, 16'd0);
        load(1'b0, 0, 32'h8000_0005, 16'd2, 16'd0);
        send_action(plbu_pkg::ACT_ADD_TOP, 1'b0, 16'hFFFF, 16'd0);
        send_action(plbu_pkg::ACT_ADD_DEEP, 1'b1, 16'hFFFF, 16'd0);
        // count and size saturate at full scale
        load(1'b0, 0, 32'd100, 16'hFFFF, 16'hFFFF);
        send_action(plbu_pkg::ACT_ADD_TOP, 1'b0, 16'd0, 16'd0);
        // cancel with size already zero
        load(1'b1, 0, 32'd50, 16'd2, 16'd0);
        send_action(plbu_pkg::ACT_CANCEL_TOP, 1'b1, 16'd0, 16'd0);
        // empty level by load, hidden list append and double clear
        load(1'b0, 7, 32'hFFFF_FFFF, 16'd0, 16'd0);
        append_hidden(1'b0, 32'h8000_0000);
        send_action(plbu_pkg::ACT_CLEAR_HIDDEN, 1'b0, 16'd0, 16'd0);
        send_action(plbu_pkg::ACT_CLEAR_HIDDEN, 1'b0, 16'd0, 16'd0);
        // unused action code is ignored
        send_word(make_word(ACT_UNUSED, 1'b1, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF, 16'hFFFF));
    endtask

    // removal refills the tail from the hidden list, else synthetically
    task automatic test_refill();
        bit s;
        for (int sd = 0; sd < 2; sd++)
        begin
            s = sd[0];
            load_ladder(s, s ? 32'sd990 : 32'sd1000, 2, 1);
            append_hidden(s, further_out(s, 1000, -500));
            append_hidden(s, further_out(s, s ? 32'sd990 : 32'sd1000, 40));
            repeat (3) send_action(plbu_pkg::ACT_CANCEL_TOP, s, 16'd0, 16'd0);
            send_action(plbu_pkg::ACT_CANCEL_DEEP, s, 16'd0, 16'hFFFF);
            send_action(plbu_pkg::ACT_ADD_DEEP, s, 16'd1, 16'd0);
        end
    endtask

    // hidden list overflow on both sides
    task automatic test_hidden_full();
        bit s;
        for (int sd = 0; sd < 2; sd++)
        begin
            s = sd[0];
            repeat (HID_MAX + 2)
            begin
                append_hidden(s, $urandom);
            end
            load_ladder(s, $urandom_range(0, 1000), 1, 3);
            repeat (10) send_action(plbu_pkg::ACT_CANCEL_TOP, s, 16'd0, 16'd0);
            send_action(plbu_pkg::ACT_CLEAR_HIDDEN, s, 16'd0, 16'd0);
        end
    endtask

    // well-formed episodes with random content, plus some noise
    task automatic test_random(input int words);
        int                 stop_at;
        logic signed [31:0] base;
        int                 step;
        bit                 s;
        stop_at = words_sent + words;
        while (words_sent < stop_at)
        begin
            calm = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 6) == 0)
            begin
                repeat ($urandom_range(3, 12)) send_word(random_noise_word());
                continue;
            end
            case ($urandom_range(0, 9))
                0:       base = 32'h7FFF_FF00 + $urandom_range(0, 200);
                1:       base = 32'h8000_0100 - $urandom_range(0, 200);
                default: base = $urandom_range(0, 200000) - 100000;
            endcase
            step = $urandom_range(1, 4);
            load_ladder(1'b0, base, step, $urandom_range(1, 5));
            load_ladder(1'b1, base - step, step, $urandom_range(1, 5));
            for (int side_i = 0; side_i < 2; side_i++)
            begin
                repeat ($urandom_range(0, 5))
                begin
                    append_hidden(side_i[0],
                                  further_out(side_i[0], base,
                                              $urandom_range(0, 60) - 10));
                end
            end
            repeat ($urandom_range(20, 45))
            begin
                s = 1'($urandom_range(0, 1));
                send_word(random_book_word(s));
            end
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        item_ch.valid     = 1'b0;
        item_ch.payload   = '0;
        result_ch.ready   = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = 8'd0;
        rst_n             = 1'b0;
        error_count       = 0;
        words_sent        = 0;
        calm              = 1'b0;
        stall_left        = 0;
        gap_ticks         = 32'(plbu_pkg::GAP_RESET);
        for (int s = 0; s < 2; s++)
        begin
            for (int k = 0; k < NLEV; k++) put_level(s[0], k, 0, 0, 0, 1'b0);
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_refill();
        write_gap(8'd255);
        test_refill();
        test_random(RANDOM_WORDS / 4);
        write_gap(8'd1);
        test_hidden_full();
        test_random(RANDOM_WORDS / 4);
        write_gap(8'($urandom_range(1, 255)));
        test_random(RANDOM_WORDS / 4);
        write_gap(8'($urandom_range(1, 255)));
        test_random(RANDOM_WORDS / 4);

        drain();
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/plbu_pkg.sv
rtl/plbu_if.sv
rtl/plbu_ram.sv
rtl/plbu_ctrl.sv
rtl/plbu_dp.sv
rtl/price_level_book_update_core.sv
dv/tb_price_level_book_update_core.sv
